// File: hdl/whp_pkg.sv
// Package for the WebP header parser: payload structs, status and format
// codes, tag characters and the tag/sync lookup functions.
// No dependencies.
package whp_pkg;

  // Status codes of a result.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_TAG   = 2'd1;
  localparam logic [1:0] ST_BAD_CHUNK = 2'd2;
  localparam logic [1:0] ST_BAD_SYNC  = 2'd3;

  // Chunk kinds; the first three double as the format field.
  localparam logic [1:0] KIND_LOSSY    = 2'd0;
  localparam logic [1:0] KIND_LOSSLESS = 2'd1;
  localparam logic [1:0] KIND_EXTENDED = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

  // Channel counts.
  localparam logic [2:0] CH_NONE = 3'd0;
  localparam logic [2:0] CH_RGB  = 3'd3;
  localparam logic [2:0] CH_RGBA = 3'd4;

  // Characters of the chunk id and fixed payload bytes.
  localparam logic [7:0] CHAR_V     = 8'h56;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_8     = 8'h38;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] VP8L_SIG   = 8'h2F;

  // Layout flag bits of the extended header.
  localparam int unsigned ALPHA_BIT = 4;
  localparam int unsigned EXIF_BIT  = 3;

  // Byte positions inside the file header.
  localparam logic [4:0] POS_TAG_END  = 5'd11;
  localparam logic [4:0] POS_LAST     = 5'd31;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } whp_byte_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  format;
    logic [24:0] width;
    logic [24:0] height;
    logic [2:0]  channels;
    logic        exif_present;
  } whp_result_t;

  // Expected byte of the "RIFF....WEBP" header; size bytes are not checked.
  function automatic logic [7:0] tag_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h52;
      4'd1:    val = 8'h49;
      4'd2:    val = 8'h46;
      4'd3:    val = 8'h46;
      4'd8:    val = 8'h57;
      4'd9:    val = 8'h45;
      4'd10:   val = 8'h42;
      4'd11:   val = 8'h50;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // Expected byte of the lossy sync code at positions 23 to 25.
  function automatic logic [7:0] sync_byte(input logic [4:0] pos);
    logic [7:0] val;
    case (pos)
      5'd23:   val = 8'h9D;
      5'd24:   val = 8'h01;
      5'd25:   val = 8'h2A;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// File: hdl/whp_if.sv
// Valid/ready channel interfaces for the byte stream and the header result.
// No dependencies.
interface whp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface whp_info_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  format;
  logic [24:0] width;
  logic [24:0] height;
  logic [2:0]  channels;
  logic        exif_present;

  modport source (output valid, output status, output format, output width,
                  output height, output channels, output exif_present, input ready);
  modport sink   (input valid, input status, input format, input width,
                  input height, input channels, input exif_present, output ready);
endinterface

// File: hdl/whp_in_reg.sv
// Input register of the WebP header parser: holds one byte transfer until
// the parser consumes it. Depends on whp_pkg.
module whp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  whp_pkg::whp_byte_t item_i,
  input  logic              take_i,
  output logic              valid_o,
  output whp_pkg::whp_byte_t item_o
);

  logic               valid_q, valid_d;
  whp_pkg::whp_byte_t item_q;

  // The register frees up in the same cycle that its byte is consumed.
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hdl/whp_parser.sv
// Parsing state and one-byte step of the WebP header parser: tag checks,
// chunk classification, sync check and dimension gathering. Depends on whp_pkg.
module whp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  whp_pkg::whp_byte_t   item_i,
  output logic                 res_valid_o,
  output whp_pkg::whp_result_t res_o
);

  logic [4:0]  pos_q, pos_d;
  logic [1:0]  kind_q, kind_d;
  logic        tags_q, tags_d;
  logic [23:0] wg_q, wg_d;
  logic [23:0] hg_q, hg_d;
  logic [31:0] fg_q, fg_d;
  logic [7:0]  fl_q, fl_d;
  logic        fin_q, fin_d;

  // Next state and result for the byte in the input register.
  always_comb begin
    logic [4:0]  pos;
    logic [1:0]  kind;
    logic [7:0]  b;

    pos    = pos_q;
    kind   = kind_q;
    tags_d = tags_q;
    wg_d   = wg_q;
    hg_d   = hg_q;
    fg_d   = fg_q;
    fl_d   = fl_q;
    fin_d  = fin_q;
    b      = item_i.data_byte;

    // A start byte restarts from the reset state with parsing enabled.
    if (item_i.first_byte) begin
      pos    = '0;
      kind   = whp_pkg::KIND_LOSSY;
      tags_d = 1'b1;
      wg_d   = '0;
      hg_d   = '0;
      fg_d   = '0;
      fl_d   = '0;
      fin_d  = 1'b0;
    end

    pos_d       = pos;
    kind_d      = kind;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (!fin_d) begin
      if (pos != whp_pkg::POS_LAST) begin
        pos_d = pos + 5'd1;
      end

      if (pos < 5'd12) begin
        // RIFF header: size bytes at positions 4 to 7 are skipped.
        if ((pos < 5'd4 || pos >= 5'd8) && b != whp_pkg::tag_byte(pos[3:0])) begin
          tags_d = 1'b0;
        end
        if (pos == whp_pkg::POS_TAG_END && !tags_d) begin
          res_valid_o  = 1'b1;
          res_o.status = whp_pkg::ST_BAD_TAG;
        end
      end else if (pos == 5'd12) begin
        kind_d = (b == whp_pkg::CHAR_V) ? whp_pkg::KIND_LOSSY : whp_pkg::KIND_UNKNOWN;
      end else if (pos == 5'd13 || pos == 5'd14) begin
        if (b != ((pos == 5'd13) ? whp_pkg::CHAR_P : whp_pkg::CHAR_8)) begin
          kind_d = whp_pkg::KIND_UNKNOWN;
        end
      end else if (pos == 5'd15) begin
        // Last character of the chunk id selects the format.
        if (kind != whp_pkg::KIND_UNKNOWN) begin
          if (b == whp_pkg::CHAR_SPACE) begin
            kind_d = whp_pkg::KIND_LOSSY;
          end else if (b == whp_pkg::CHAR_L) begin
            kind_d = whp_pkg::KIND_LOSSLESS;
          end else if (b == whp_pkg::CHAR_X) begin
            kind_d = whp_pkg::KIND_EXTENDED;
          end else begin
            kind_d = whp_pkg::KIND_UNKNOWN;
          end
        end
        if (kind_d == whp_pkg::KIND_UNKNOWN) begin
          res_valid_o  = 1'b1;
          res_o.status = whp_pkg::ST_BAD_CHUNK;
        end
      end else if (pos >= 5'd20) begin
        case (kind)
          whp_pkg::KIND_LOSSY: begin
            if (pos >= 5'd23 && pos <= 5'd25) begin
              if (b != whp_pkg::sync_byte(pos)) begin
                res_valid_o  = 1'b1;
                res_o.status = whp_pkg::ST_BAD_SYNC;
                res_o.format = whp_pkg::KIND_LOSSY;
              end
            end else if (pos == 5'd26) begin
              wg_d = wg_q | {16'd0, b};
            end else if (pos == 5'd27) begin
              wg_d = wg_q | {8'd0, b, 8'd0};
            end else if (pos == 5'd28) begin
              hg_d = hg_q | {16'd0, b};
            end else if (pos == 5'd29) begin
              hg_d               = hg_q | {8'd0, b, 8'd0};
              res_valid_o        = 1'b1;
              res_o.status       = whp_pkg::ST_OK;
              res_o.format       = whp_pkg::KIND_LOSSY;
              res_o.width        = {11'd0, wg_d[13:0]};
              res_o.height       = {11'd0, hg_d[13:0]};
              res_o.channels     = whp_pkg::CH_RGB;
            end
          end
          whp_pkg::KIND_LOSSLESS: begin
            if (pos == 5'd20) begin
              if (b != whp_pkg::VP8L_SIG) begin
                res_valid_o  = 1'b1;
                res_o.status = whp_pkg::ST_BAD_SYNC;
                res_o.format = whp_pkg::KIND_LOSSLESS;
              end
            end else if (pos == 5'd21) begin
              fg_d = fg_q | {24'd0, b};
            end else if (pos == 5'd22) begin
              fg_d = fg_q | {16'd0, b, 8'd0};
            end else if (pos == 5'd23) begin
              fg_d = fg_q | {8'd0, b, 16'd0};
            end else if (pos == 5'd24) begin
              fg_d           = fg_q | {b, 24'd0};
              res_valid_o    = 1'b1;
              res_o.status   = whp_pkg::ST_OK;
              res_o.format   = whp_pkg::KIND_LOSSLESS;
              res_o.width    = {11'd0, fg_d[13:0]} + 25'd1;
              res_o.height   = {11'd0, fg_d[27:14]} + 25'd1;
              res_o.channels = fg_d[28] ? whp_pkg::CH_RGBA : whp_pkg::CH_RGB;
            end
          end
          default: begin
            // Extended layout; an unknown chunk never gets this far.
            if (pos == 5'd20) begin
              fl_d = b;
            end else if (pos == 5'd24) begin
              wg_d = wg_q | {16'd0, b};
            end else if (pos == 5'd25) begin
              wg_d = wg_q | {8'd0, b, 8'd0};
            end else if (pos == 5'd26) begin
              wg_d = wg_q | {b, 16'd0};
            end else if (pos == 5'd27) begin
              hg_d = hg_q | {16'd0, b};
            end else if (pos == 5'd28) begin
              hg_d = hg_q | {8'd0, b, 8'd0};
            end else if (pos == 5'd29) begin
              hg_d               = hg_q | {b, 16'd0};
              res_valid_o        = 1'b1;
              res_o.status       = whp_pkg::ST_OK;
              res_o.format       = whp_pkg::KIND_EXTENDED;
              res_o.width        = {1'b0, wg_d} + 25'd1;
              res_o.height       = {1'b0, hg_d} + 25'd1;
              res_o.channels     = fl_d[whp_pkg::ALPHA_BIT] ? whp_pkg::CH_RGBA
                                                            : whp_pkg::CH_RGB;
              res_o.exif_present = fl_d[whp_pkg::EXIF_BIT];
            end
          end
        endcase
      end

      // One result per file; later bytes are ignored until the next start.
      if (res_valid_o) begin
        fin_d = 1'b1;
      end
    end
  end

  // Parsing state advances once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kind_q <= whp_pkg::KIND_LOSSY;
      tags_q <= 1'b1;
      wg_q   <= '0;
      hg_q   <= '0;
      fg_q   <= '0;
      fl_q   <= '0;
      fin_q  <= 1'b1;
    end else if (step_i) begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
      tags_q <= tags_d;
      wg_q   <= wg_d;
      hg_q   <= hg_d;
      fg_q   <= fg_d;
      fl_q   <= fl_d;
      fin_q  <= fin_d;
    end
  end

endmodule

// File: hdl/webp_header_info_parser.sv
// WebP header parser top level: input register, parsing step, result register.
// The last header byte is held in the input register, its result in the result register.
// Throughput: one byte per cycle; a stalled result stops byte consumption and the input stalls.
// Reset: asynchronous, active low; the parser then ignores bytes until a start byte.
// Depends on whp_pkg, whp_if, whp_in_reg and whp_parser.
module webp_header_info_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  whp_byte_if.sink   byte_i,
  whp_info_if.source info_o
);

  whp_pkg::whp_byte_t   in_item;
  whp_pkg::whp_byte_t   held_item;
  logic                 held_valid;
  logic                 take;
  logic                 res_valid;
  whp_pkg::whp_result_t res;
  logic                 out_valid_q, out_valid_d;
  whp_pkg::whp_result_t res_q;

  assign in_item.data_byte  = byte_i.data_byte;
  assign in_item.first_byte = byte_i.first_byte;

  // A held byte is consumed when the result register is free or being drained.
  assign take = held_valid && (!out_valid_q || info_o.ready);

  whp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_i.valid),
    .ready_o (byte_i.ready),
    .item_i  (in_item),
    .take_i  (take),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  whp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  assign out_valid_d = take ? res_valid : (out_valid_q && !info_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res_valid) begin
      res_q <= res;
    end
  end

  assign info_o.valid        = out_valid_q;
  assign info_o.status       = res_q.status;
  assign info_o.format       = res_q.format;
  assign info_o.width        = res_q.width;
  assign info_o.height       = res_q.height;
  assign info_o.channels     = res_q.channels;
  assign info_o.exif_present = res_q.exif_present;

`ifndef ASSERT_OFF
  // An error result carries no dimensions and no channels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status != whp_pkg::ST_OK |->
      res_q.width == 25'd0 && res_q.height == 25'd0 && res_q.channels == whp_pkg::CH_NONE)
    else $error("error result with nonzero dimensions");

  // A good result has three or four channels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == whp_pkg::ST_OK |->
      res_q.channels == whp_pkg::CH_RGB || res_q.channels == whp_pkg::CH_RGBA)
    else $error("good result with bad channel count");

  // A full input register behind a stalled result blocks new transfers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid && out_valid_q && !info_o.ready |-> !byte_i.ready)
    else $error("input accepted while pipeline stalled");

  // A new result only appears after a byte was consumed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(take))
    else $error("result appeared without a consumed byte");
`endif

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the WebP header parser: drives file bytes
// through the valid/ready byte channel and checks every header result.
// Depends on whp_pkg, whp_if and the webp_header_info_parser top level.
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 800;

  // Fixed header bytes: "RIFF", size (unchecked), "WEBP"; and the lossy sync code.
  localparam logic [95:0] HDR_TAG    = {"RIFF", 32'h0, "WEBP"};
  localparam logic [23:0] LOSSY_SYNC = 24'h9D012A;

  logic clk_i;
  logic rst_ni;

  whp_byte_if byte_if ();
  whp_info_if info_if ();

  webp_header_info_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .info_o (info_if)
  );

  // Clock with a 10 unit period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Header parser state, mirroring the block after reset.
  logic [4:0]  hdr_pos   = '0;
  logic [1:0]  hdr_kind  = whp_pkg::KIND_LOSSY;
  logic        tags_good = 1'b1;
  logic [23:0] wid_acc   = '0;
  logic [23:0] hgt_acc   = '0;
  logic [31:0] feat_acc  = '0;
  logic [7:0]  layout_q  = '0;
  logic        hdr_done  = 1'b1;

  whp_pkg::whp_result_t expected_info[$];
  int          bytes_sent   = 0;
  int          err_count    = 0;
  int          gap_pct      = 30;
  int          stall_pct    = 30;
  int          ready_hold   = 0;
  int          idle_cycles  = 0;
  logic [7:0]  file_bytes[$];

  // Random idle length: mostly none, then mostly short, a few long.
  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the header parser by one accepted byte and queue any result it yields.
  task automatic parse_byte(input logic [7:0] b, input logic first);
    logic [4:0]           pos;
    whp_pkg::whp_result_t res;
    logic                 emit;
    emit = 1'b0;
    res  = '0;
    if (first) begin
      hdr_pos   = '0;
      hdr_kind  = whp_pkg::KIND_LOSSY;
      tags_good = 1'b1;
      wid_acc   = '0;
      hgt_acc   = '0;
      feat_acc  = '0;
      layout_q  = '0;
      hdr_done  = 1'b0;
    end
    if (hdr_done) return;
    pos = hdr_pos;
    if (hdr_pos != whp_pkg::POS_LAST) hdr_pos = hdr_pos + 5'd1;

    if (pos < 5'd12) begin
      // The four size bytes are not compared.
      if ((pos < 5'd4 || pos >= 5'd8) && b != HDR_TAG[95 - 8 * int'(pos) -: 8])
        tags_good = 1'b0;
      if (pos == whp_pkg::POS_TAG_END && !tags_good) begin
        emit       = 1'b1;
        res.status = whp_pkg::ST_BAD_TAG;
        res.format = whp_pkg::KIND_LOSSY;
      end
    end else if (pos == 5'd12) begin
      hdr_kind = (b == whp_pkg::CHAR_V) ? whp_pkg::KIND_LOSSY : whp_pkg::KIND_UNKNOWN;
    end else if (pos == 5'd13) begin
      if (b != whp_pkg::CHAR_P) hdr_kind = whp_pkg::KIND_UNKNOWN;
    end else if (pos == 5'd14) begin
      if (b != whp_pkg::CHAR_8) hdr_kind = whp_pkg::KIND_UNKNOWN;
    end else if (pos == 5'd15) begin
      // The last id character picks the chunk kind.
      if (hdr_kind != whp_pkg::KIND_UNKNOWN) begin
        if (b == whp_pkg::CHAR_SPACE) hdr_kind = whp_pkg::KIND_LOSSY;
        else if (b == whp_pkg::CHAR_L) hdr_kind = whp_pkg::KIND_LOSSLESS;
        else if (b == whp_pkg::CHAR_X) hdr_kind = whp_pkg::KIND_EXTENDED;
        else hdr_kind = whp_pkg::KIND_UNKNOWN;
      end
      if (hdr_kind == whp_pkg::KIND_UNKNOWN) begin
        emit       = 1'b1;
        res.status = whp_pkg::ST_BAD_CHUNK;
        res.format = whp_pkg::KIND_LOSSY;
      end
    end else if (pos >= 5'd20) begin
      case (hdr_kind)
        whp_pkg::KIND_LOSSY: begin
          if (pos >= 5'd23 && pos <= 5'd25) begin
            if (b != LOSSY_SYNC[23 - 8 * (int'(pos) - 23) -: 8]) begin
              emit       = 1'b1;
              res.status = whp_pkg::ST_BAD_SYNC;
              res.format = whp_pkg::KIND_LOSSY;
            end
          end else if (pos == 5'd26) begin
            wid_acc[7:0] = b;
          end else if (pos == 5'd27) begin
            wid_acc[15:8] = b;
          end else if (pos == 5'd28) begin
            hgt_acc[7:0] = b;
          end else if (pos == 5'd29) begin
            hgt_acc[15:8] = b;
            emit         = 1'b1;
            res.status   = whp_pkg::ST_OK;
            res.format   = whp_pkg::KIND_LOSSY;
            res.width    = {11'd0, wid_acc[13:0]};
            res.height   = {11'd0, hgt_acc[13:0]};
            res.channels = whp_pkg::CH_RGB;
          end
        end
        whp_pkg::KIND_LOSSLESS: begin
          if (pos == 5'd20) begin
            if (b != whp_pkg::VP8L_SIG) begin
              emit       = 1'b1;
              res.status = whp_pkg::ST_BAD_SYNC;
              res.format = whp_pkg::KIND_LOSSLESS;
            end
          end else if (pos <= 5'd24) begin
            feat_acc[8 * (int'(pos) - 21) +: 8] = b;
            if (pos == 5'd24) begin
              emit         = 1'b1;
              res.status   = whp_pkg::ST_OK;
              res.format   = whp_pkg::KIND_LOSSLESS;
              res.width    = {11'd0, feat_acc[13:0]} + 25'd1;
              res.height   = {11'd0, feat_acc[27:14]} + 25'd1;
              res.channels = feat_acc[28] ? whp_pkg::CH_RGBA : whp_pkg::CH_RGB;
            end
          end
        end
        default: begin
          // Extended layout: flags, three reserved bytes, then 24-bit sizes minus one.
          if (pos == 5'd20) begin
            layout_q = b;
          end else if (pos >= 5'd24 && pos <= 5'd26) begin
            wid_acc[8 * (int'(pos) - 24) +: 8] = b;
          end else if (pos >= 5'd27 && pos <= 5'd29) begin
            hgt_acc[8 * (int'(pos) - 27) +: 8] = b;
            if (pos == 5'd29) begin
              emit             = 1'b1;
              res.status       = whp_pkg::ST_OK;
              res.format       = whp_pkg::KIND_EXTENDED;
              res.width        = {1'b0, wid_acc} + 25'd1;
              res.height       = {1'b0, hgt_acc} + 25'd1;
              res.channels     = layout_q[whp_pkg::ALPHA_BIT] ? whp_pkg::CH_RGBA
                                                              : whp_pkg::CH_RGB;
              res.exif_present = layout_q[whp_pkg::EXIF_BIT];
            end
          end
        end
      endcase
    end

    if (emit) begin
      expected_info.push_back(res);
      hdr_done = 1'b1;
    end
  endtask

  task automatic report_error(input string msg);
    err_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [24:0] got,
                             input logic [24:0] want);
    if (got !== want)
      report_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Send one byte: called at a falling edge, returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = pick_gap(gap_pct);
    if (gap > 0) begin
      byte_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_if.valid      = 1'b1;
    byte_if.data_byte  = b;
    byte_if.first_byte = first;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    bytes_sent++;
    parse_byte(b, first);
    @(negedge clk_i);
  endtask

  // Assemble a header in file_bytes. dim_a/dim_b are the size fields of the
  // chunk (features in dim_a for lossless); flags is the extended layout byte.
  task automatic build_file(input logic [1:0] kind, input logic [31:0] dim_a,
                            input logic [31:0] dim_b, input logic [7:0] flags);
    file_bytes.delete();
    for (int i = 0; i < 12; i++)
      file_bytes.push_back((i >= 4 && i < 8) ? 8'($urandom) : HDR_TAG[95 - 8 * i -: 8]);
    file_bytes.push_back(whp_pkg::CHAR_V);
    file_bytes.push_back(whp_pkg::CHAR_P);
    file_bytes.push_back(whp_pkg::CHAR_8);
    case (kind)
      whp_pkg::KIND_LOSSY:    file_bytes.push_back(whp_pkg::CHAR_SPACE);
      whp_pkg::KIND_LOSSLESS: file_bytes.push_back(whp_pkg::CHAR_L);
      whp_pkg::KIND_EXTENDED: file_bytes.push_back(whp_pkg::CHAR_X);
      default:                file_bytes.push_back(8'($urandom));
    endcase
    repeat (4) file_bytes.push_back(8'($urandom));
    case (kind)
      whp_pkg::KIND_LOSSY: begin
        repeat (3) file_bytes.push_back(8'($urandom));
        for (int i = 0; i < 3; i++) file_bytes.push_back(LOSSY_SYNC[23 - 8 * i -: 8]);
        for (int i = 0; i < 2; i++) file_bytes.push_back(dim_a[8 * i +: 8]);
        for (int i = 0; i < 2; i++) file_bytes.push_back(dim_b[8 * i +: 8]);
      end
      whp_pkg::KIND_LOSSLESS: begin
        file_bytes.push_back(whp_pkg::VP8L_SIG);
        for (int i = 0; i < 4; i++) file_bytes.push_back(dim_a[8 * i +: 8]);
      end
      whp_pkg::KIND_EXTENDED: begin
        file_bytes.push_back(flags);
        repeat (3) file_bytes.push_back(8'($urandom));
        for (int i = 0; i < 3; i++) file_bytes.push_back(dim_a[8 * i +: 8]);
        for (int i = 0; i < 3; i++) file_bytes.push_back(dim_b[8 * i +: 8]);
      end
      default: repeat (10) file_bytes.push_back(8'($urandom));
    endcase
  endtask

  task automatic corrupt_byte(input int idx);
    file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
  endtask

  task automatic truncate_file(input int len);
    while (file_bytes.size() > len) void'(file_bytes.pop_back());
  endtask

  // Send file_bytes with a start on the first byte, then some bytes past the header.
  task automatic send_file(input int junk);
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
    repeat (junk) send_byte(8'($urandom), 1'b0);
  endtask

  // Bytes without a start after reset must be ignored.
  task automatic test_idle_after_reset;
    gap_pct   = 30;
    stall_pct = 30;
    repeat (5) send_byte(8'($urandom), 1'b0);
  endtask

  // Well-formed headers of all three formats, at field extremes and with random fields.
  task automatic test_good_headers;
    gap_pct   = 0;
    stall_pct = 0;
    build_file(whp_pkg::KIND_LOSSY, 32'h0, 32'h0, 8'h00);               // zero dimensions
    send_file(0);
    build_file(whp_pkg::KIND_LOSSY, 32'hFFFF, 32'hFFFF, 8'h00);
    send_file(2);
    gap_pct   = 30;
    stall_pct = 30;
    build_file(whp_pkg::KIND_LOSSY, $urandom, $urandom, 8'h00);
    send_file(0);
    build_file(whp_pkg::KIND_LOSSLESS, 32'h0, 32'h0, 8'h00);
    send_file(0);
    build_file(whp_pkg::KIND_LOSSLESS, 32'hFFFF_FFFF, 32'h0, 8'h00);
    send_file(1);
    build_file(whp_pkg::KIND_LOSSLESS, 32'hEFFF_FFFF, 32'h0, 8'h00);
    send_file(0);
    build_file(whp_pkg::KIND_EXTENDED, 32'h0, 32'h0, 8'h18);            // alpha and EXIF
    send_file(0);
    build_file(whp_pkg::KIND_EXTENDED, 32'hFF_FFFF, 32'hFF_FFFF, 8'hE7); // largest, no alpha or EXIF flag
    send_file(0);
    build_file(whp_pkg::KIND_EXTENDED, $urandom, $urandom, 8'h10);
    send_file(0);
    build_file(whp_pkg::KIND_EXTENDED, $urandom, $urandom, 8'h08);
    send_file(0);
  endtask

  // Errors in the RIFF or WEBP tag; a changed size byte is not an error.
  task automatic test_bad_tags;
    for (int k = 0; k < 3; k++) begin
      build_file(whp_pkg::KIND_LOSSY, $urandom, $urandom, 8'h00);
      corrupt_byte((k == 0) ? 0 : (k == 1) ? 11 : 5);
      send_file(1);
    end
  endtask

  // Unknown chunk ids, wrong in each of the four characters.
  task automatic test_bad_chunk_ids;
    for (int idx = 12; idx < 15; idx++) begin
      build_file(whp_pkg::KIND_LOSSLESS, $urandom, 32'h0, 8'h00);
      corrupt_byte(idx);
      send_file(1);
    end
    build_file(whp_pkg::KIND_EXTENDED, $urandom, $urandom, 8'h00);
    file_bytes[15] = 8'h41;
    send_file(1);
  endtask

  // Bad sync code at each lossy sync byte and a bad lossless signature.
  task automatic test_bad_sync;
    for (int idx = 23; idx < 26; idx++) begin
      build_file(whp_pkg::KIND_LOSSY, $urandom, $urandom, 8'h00);
      corrupt_byte(idx);
      send_file(1);
    end
    build_file(whp_pkg::KIND_LOSSLESS, $urandom, 32'h0, 8'h00);
    corrupt_byte(20);
    send_file(1);
  endtask

  // A short file abandoned by a new start, then trailing bytes after a result.
  task automatic test_restart_and_trailing;
    build_file(whp_pkg::KIND_LOSSY, $urandom, $urandom, 8'h00);
    truncate_file(20);
    send_file(0);
    build_file(whp_pkg::KIND_LOSSLESS, $urandom, 32'h0, 8'h00);
    send_file(8);
  endtask

  // Mostly well-formed headers with random content, some broken, some noise.
  task automatic test_random_files;
    int         pick;
    logic [1:0] kind;
    while (bytes_sent < ITEM_TARGET) begin
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : 30;
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
      pick      = $urandom_range(0, 99);
      if (pick < 85) begin
        pick = $urandom_range(0, 9);
        kind = (pick < 3) ? whp_pkg::KIND_LOSSY : (pick < 6) ? whp_pkg::KIND_LOSSLESS :
               (pick < 9) ? whp_pkg::KIND_EXTENDED : whp_pkg::KIND_UNKNOWN;
        build_file(kind, $urandom, $urandom, 8'($urandom));
        if ($urandom_range(0, 99) < 15) corrupt_byte($urandom_range(0, file_bytes.size() - 1));
        if ($urandom_range(0, 99) < 10) truncate_file($urandom_range(1, file_bytes.size() - 1));
        send_file($urandom_range(0, 4));
      end else begin
        repeat ($urandom_range(1, 30)) send_byte(8'($urandom), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // Result sink with random stalls.
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      info_if.ready = 1'b0;
      ready_hold--;
    end else begin
      info_if.ready = 1'b1;
      ready_hold    = pick_gap(stall_pct);
    end
  end

  // Compare each result transfer with the oldest pending header.
  always @(posedge clk_i) begin : check_info
    whp_pkg::whp_result_t want;
    if (rst_ni && info_if.valid && info_if.ready) begin
      if (expected_info.size() == 0) begin
        report_error("result transfer with no header pending");
      end else begin
        want = expected_info.pop_front();
        check_field("status", 25'(info_if.status), 25'(want.status));
        check_field("format", 25'(info_if.format), 25'(want.format));
        check_field("width", info_if.width, want.width);
        check_field("height", info_if.height, want.height);
        check_field("channels", 25'(info_if.channels), 25'(want.channels));
        check_field("exif_present", 25'(info_if.exif_present), 25'(want.exif_present));
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (info_if.valid && info_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("webp_header_info_parser: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    byte_if.valid      = 1'b0;
    byte_if.data_byte  = '0;
    byte_if.first_byte = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_after_reset();
    test_good_headers();
    test_bad_tags();
    test_bad_chunk_ids();
    test_bad_sync();
    test_restart_and_trailing();
    test_random_files();

    // Drain pending results, then wait for any stray result.
    byte_if.valid = 1'b0;
    while (expected_info.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("webp_header_info_parser: match");
    end else begin
      $display("webp_header_info_parser: mismatch");
    end
    $finish;
  end

endmodule
